@@ rtl/core/position_density_histogram_2d_macros.svh @@
// Assertion macros for the 2-D position histogram.
// Used by the top level; no other dependencies.
`ifndef POSITION_DENSITY_HISTOGRAM_2D_MACROS_SVH
`define POSITION_DENSITY_HISTOGRAM_2D_MACROS_SVH
`ifndef SYNTH
`define PHD2_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("phd2 assertion failed");
`define PHD2_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("phd2 assertion failed");
`else
`define PHD2_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PHD2_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/phd2_pkg.sv @@
// Shared types and constants for the 2-D position histogram.
// No dependencies.
`default_nettype none
package phd2_pkg;

  localparam int MAX_BINS_PER_SIDE_DEF = 64;
  localparam int COUNT_BITS_DEF        = 32;
  localparam int RAM_DEPTH_DEF         = MAX_BINS_PER_SIDE_DEF * MAX_BINS_PER_SIDE_DEF;

  localparam int COORD_W     = 24;
  localparam int IBL_W       = 24;
  localparam int NORM_W      = 32;
  localparam int BPS_W       = 7;
  localparam int BIN_W       = 12;
  localparam int OUT_COUNT_W = 32;
  localparam int DENS_W      = 64;
  localparam int AXIS_PROD_W = COORD_W + IBL_W;
  localparam int AXIS_FRAC_W = 32;
  localparam int AXIS_INT_W  = AXIS_PROD_W - AXIS_FRAC_W;
  localparam int DENS_FULL_W = 80;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 112;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [BPS_W-1:0]  BPS_RST  = 7'd64;
  localparam logic [IBL_W-1:0]  IBL_RST  = 24'd1318724;
  localparam logic [NORM_W-1:0] NORM_RST = 32'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BINS_PER_SIDE = 2'd0,
    CFG_INV_BIN_LEN   = 2'd1,
    CFG_NORM_SCALE    = 2'd2
  } phd2_cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_IDX,
    ST_RMW,
    ST_MUL,
    ST_OUT
  } phd2_state_t;

endpackage
`default_nettype wire

@@ rtl/core/position_density_histogram_2d.sv @@
// Top level of the 2-D position histogram: binning, count RAM update, density.
// Depends on phd2_pkg, phd2_ram and position_density_histogram_2d_macros.svh.
//
//   channel | dir | handshake            | word
//   --------+-----+----------------------+-------------------------------------------
//   s_*     | in  | s_tvalid / s_tready  | tuser: command; tdata: x_pos, y_pos, read_bin
//   m_*     | out | m_tvalid / m_tready  | tdata: bin_index, bin_count, bin_density
//   cfg_*   | in  | cfg_valid / cfg_ready| cfg_index, cfg_data (register write)
//
// One word at a time: accept, axis bin + RAM read, read-modify-write, density
// partial products, combine. The next word is taken only once the result of the
// last one is loaded into the output register.
// After reset the count RAM is cleared one entry a cycle, all MAX_BINS_PER_SIDE^2
// entries (4096 by default); s_tready stays low then, cfg writes still go in.
// A stalled result waits in the output register while the next word proceeds.
`default_nettype none
`include "position_density_histogram_2d_macros.svh"
module position_density_histogram_2d
  import phd2_pkg::*;
#(
  parameter int MAX_BINS_PER_SIDE = MAX_BINS_PER_SIDE_DEF,
  parameter int COUNT_BITS        = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [23:0] x_pos, [47:24] y_pos, [59:48] read_bin, [63:60] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [0] command (0 add, 1 read)
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [11:0] bin_index, [43:12] bin_count, [107:44] bin_density, [111:108] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH  = MAX_BINS_PER_SIDE * MAX_BINS_PER_SIDE;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int NW     = $clog2(MAX_BINS_PER_SIDE + 1);
  localparam int XBW    = MAX_BINS_PER_SIDE > 1 ? $clog2(MAX_BINS_PER_SIDE) : 1;
  localparam int IDXW   = 2 * NW;
  localparam int CLO    = (COUNT_BITS + 1) / 2;
  localparam int CHI    = COUNT_BITS - CLO;
  localparam int PAD_W  = OUT_TDATA_W - BIN_W - OUT_COUNT_W - DENS_W;

  phd2_state_t state, state_next;

  // configuration
  logic [BPS_W-1:0]  bins_per_side;
  logic [IBL_W-1:0]  inverse_bin_length;
  logic [NORM_W-1:0] normalization_scale;

  // grid size clamped to 1..MAX_BINS_PER_SIDE
  logic [NW-1:0] grid_n;
  logic [NW-1:0] grid_n_m1;

  // word registers
  logic                   cmd_q;
  logic [BIN_W-1:0]       rbin_q;
  logic [AXIS_PROD_W-1:0] px;
  logic [AXIS_PROD_W-1:0] py;

  logic [AXIS_INT_W-1:0] x_whole, y_whole;
  logic [XBW-1:0]        xb, yb;
  logic [IDXW-1:0]       idx_full;
  logic                  rd_in_range;

  logic [ADDR_W-1:0] addr_q;
  logic [BIN_W-1:0]  bin_q;
  logic              zero_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [COUNT_BITS-1:0] cnt_upd;
  logic [CLO+NORM_W-1:0] prod_lo;
  logic [CHI+NORM_W-1:0] prod_hi;
  logic [DENS_FULL_W-1:0] dens_full;
  logic [DENS_W-1:0]      dens_sat;
  logic [63:0]            cnt_wide;
  logic [OUT_COUNT_W-1:0] cnt_sat;

  // output register
  logic [BIN_W-1:0]       out_bin;
  logic [OUT_COUNT_W-1:0] out_count;
  logic [DENS_W-1:0]      out_dens;

  // RAM
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;
  logic [ADDR_W-1:0]     clr_addr;
  logic                  out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_per_side       <= BPS_RST;
      inverse_bin_length  <= IBL_RST;
      normalization_scale <= NORM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BINS_PER_SIDE: bins_per_side       <= cfg_data[BPS_W-1:0];
        CFG_INV_BIN_LEN:   inverse_bin_length  <= cfg_data[IBL_W-1:0];
        CFG_NORM_SCALE:    normalization_scale <= cfg_data[NORM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bins_per_side == '0) begin
      grid_n = NW'(1);
    end else if (32'(bins_per_side) > 32'(MAX_BINS_PER_SIDE)) begin
      grid_n = NW'(MAX_BINS_PER_SIDE);
    end else begin
      grid_n = NW'(bins_per_side);
    end
    grid_n_m1 = grid_n - 1'b1;
  end

  // axis bins: integer part of the Q.32 product, clamped to the grid
  assign x_whole = px[AXIS_PROD_W-1:AXIS_FRAC_W];
  assign y_whole = py[AXIS_PROD_W-1:AXIS_FRAC_W];
  assign xb = (x_whole > AXIS_INT_W'(grid_n_m1)) ? XBW'(grid_n_m1) : XBW'(x_whole);
  assign yb = (y_whole > AXIS_INT_W'(grid_n_m1)) ? XBW'(grid_n_m1) : XBW'(y_whole);
  assign idx_full    = IDXW'(xb) * IDXW'(grid_n) + IDXW'(yb);
  assign rd_in_range = 32'(rbin_q) < 32'(DEPTH);
  assign ram_raddr   = cmd_q ? ADDR_W'(rbin_q) : ADDR_W'(idx_full);

  // saturating increment
  assign cnt_upd = (&ram_rdata) ? ram_rdata : ram_rdata + 1'b1;

  // density = count * norm, from two partial products
  assign dens_full = DENS_FULL_W'(prod_lo) + (DENS_FULL_W'(prod_hi) << CLO);
  assign dens_sat  = (dens_full[DENS_FULL_W-1:DENS_W] != '0) ? '1 : dens_full[DENS_W-1:0];
  assign cnt_wide  = 64'(cnt_q);
  assign cnt_sat   = (cnt_wide[63:OUT_COUNT_W] != '0) ? '1 : cnt_wide[OUT_COUNT_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (s_tvalid) state_next = ST_IDX;
      ST_IDX:   state_next = ST_RMW;
      ST_RMW:   state_next = ST_MUL;
      ST_MUL:   state_next = ST_OUT;
      ST_OUT:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready  = (state == ST_IDLE);
    ram_re    = (state == ST_IDX);
    ram_we    = (state == ST_CLEAR) || ((state == ST_RMW) && !cmd_q);
    ram_waddr = (state == ST_CLEAR) ? clr_addr : addr_q;
    ram_wdata = (state == ST_CLEAR) ? '0 : cnt_upd;
    out_load  = (state == ST_OUT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_q  <= s_tuser;
      rbin_q <= s_tdata[59:48];
      px     <= AXIS_PROD_W'(s_tdata[23:0]) * AXIS_PROD_W'(inverse_bin_length);
      py     <= AXIS_PROD_W'(s_tdata[47:24]) * AXIS_PROD_W'(inverse_bin_length);
    end
    if (state == ST_IDX) begin
      addr_q <= ram_raddr;
      bin_q  <= cmd_q ? rbin_q : BIN_W'(idx_full);
      zero_q <= cmd_q && !rd_in_range;
    end
    if (state == ST_RMW) begin
      if (!cmd_q) begin
        cnt_q <= cnt_upd;
      end else if (zero_q) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= ram_rdata;
      end
    end
    if (state == ST_MUL) begin
      prod_lo <= (CLO + NORM_W)'(cnt_q[CLO-1:0]) * (CLO + NORM_W)'(normalization_scale);
      prod_hi <= (CHI + NORM_W)'(cnt_q[COUNT_BITS-1:CLO]) *
                 (CHI + NORM_W)'(normalization_scale);
    end
    if (out_load) begin
      out_bin   <= bin_q;
      out_count <= cnt_sat;
      out_dens  <= dens_sat;
    end
  end

  assign m_tdata = {PAD_W'(0), out_dens, out_count, out_bin};

  phd2_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(DEPTH)
  ) u_counts (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  `PHD2_ASSERT_IMPL(a_we_phase, clk, rst, ram_we, (state == ST_CLEAR) || (state == ST_RMW))
  `PHD2_ASSERT_IMPL(a_axis_in_grid, clk, rst, state == ST_IDX, NW'(xb) < grid_n && NW'(yb) < grid_n)
  `PHD2_ASSERT_NEXT(a_out_wait, clk, rst, (state == ST_OUT) && m_tvalid && !m_tready, state == ST_OUT)
  `PHD2_ASSERT_NEXT(a_accept_seq, clk, rst, s_tvalid && s_tready, state == ST_IDX)

endmodule
`default_nettype wire

@@ rtl/core/phd2_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on phd2_pkg for default sizes.
`default_nettype none
module phd2_ram
  import phd2_pkg::*;
#(
  parameter int WIDTH = COUNT_BITS_DEF,
  parameter int DEPTH = RAM_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking bench for position_density_histogram_2d: position adds and bin reads.
// It checks every result word, predicted or hand-written, over several register settings.
// Needs phd2_pkg and the RTL of the block; nothing else.
`timescale 1ns / 1ps
module tb;
  import phd2_pkg::*;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam int GRID_CELLS        = MAX_BINS_PER_SIDE_DEF * MAX_BINS_PER_SIDE_DEF;
  localparam int WORDS_PER_SEGMENT = 55;
  localparam int N_SEGMENTS        = 7;    // register settings after the default one
  localparam int HOLD_SEGMENT      = 2;    // sink stalls hard at the start of this one
  localparam int LONG_HOLD         = 60;
  // The post-reset RAM clear is quiet time on every channel; leave plenty of room.
  localparam int QUIET_LIMIT       = 20000;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic [BIN_W-1:0]   read_bin;
  } position_word_t;

  typedef struct packed {
    logic [BIN_W-1:0]       bin_index;
    logic [OUT_COUNT_W-1:0] bin_count;
    logic [DENS_W-1:0]      bin_density;
  } bin_report_t;

  // One row of the directed part; typed rows carry a hand-written result.
  typedef struct packed {
    position_word_t word;
    logic           typed;
    bin_report_t    report;
  } directed_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // [23:0] x_pos, [47:24] y_pos, [59:48] read_bin
  logic                   s_tuser;   // [0] command
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [11:0] bin_index, [43:12] bin_count, [107:44] bin_density
  logic                   cfg_valid;
  logic                   cfg_ready;
  phd2_cfg_reg_t          cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Bench-side histogram state and register copies.
  logic [COUNT_BITS_DEF-1:0] bin_tally [GRID_CELLS];
  logic [BPS_W-1:0]          grid_bps;
  logic [IBL_W-1:0]          grid_ibl;
  logic [NORM_W-1:0]         grid_norm;

  bin_report_t   awaited_reports[$];
  logic [BIN_W-1:0] filled_bins[$];   // bins that took an add, so reads find counts
  directed_row_t directed_rows[$];

  bit calm;            // no idling on either side
  int hold_asks;       // bumped by the source to request one long sink stall
  int failures;
  int quiet_cycles;
  int words_sent, adds_sent, reads_sent, reports_checked, settings_loaded;

  position_density_histogram_2d dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Histogram predictor
  // ---------------------------------------------------------------------------

  // Codes 0 and above 64 are clamped into the legal grid range.
  function automatic logic [6:0] grid_side();
    logic [6:0] n;
    n = grid_bps;
    if (n == 7'd0) n = 7'd1;
    if (n > 7'(MAX_BINS_PER_SIDE_DEF)) n = 7'(MAX_BINS_PER_SIDE_DEF);
    return n;
  endfunction

  // Q.8 coordinate times Q.24 reciprocal is exact in 48 bits; the integer part
  // sits from bit 32 up and saturates at the last bin of the axis.
  function automatic logic [15:0] axis_bin_of(input logic [COORD_W-1:0] c,
                                               input logic [6:0] n);
    logic [AXIS_PROD_W-1:0] prod;
    logic [15:0]            whole;
    prod  = {24'd0, c} * {24'd0, grid_ibl};
    whole = prod[AXIS_PROD_W-1:AXIS_FRAC_W];
    if (whole > {9'd0, n} - 16'd1) whole = {9'd0, n} - 16'd1;
    return whole;
  endfunction

  // Applies one word to the bench histogram and returns the result word.
  // With 32-bit counters and a 12-bit index the density never overflows and
  // no read can fall outside the count RAM, so those cases need no branch.
  function automatic bin_report_t histogram_apply(input position_word_t w);
    bin_report_t         r;
    logic [6:0]          n;
    logic [15:0]         xb, yb;
    logic [31:0]         lin;
    logic [BIN_W-1:0]    idx;
    logic [OUT_COUNT_W-1:0] c;
    if (w.cmd == CMD_ADD) begin
      n   = grid_side();
      xb  = axis_bin_of(w.x_pos, n);
      yb  = axis_bin_of(w.y_pos, n);
      lin = xb * n + yb;
      idx = lin[BIN_W-1:0];
      if (bin_tally[idx] != '1) bin_tally[idx] = bin_tally[idx] + 1'b1;
    end else begin
      idx = w.read_bin;
    end
    c             = bin_tally[idx];
    r.bin_index   = idx;
    r.bin_count   = c;
    r.bin_density = {32'd0, c} * {32'd0, grid_norm};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic stage_row(input logic cmd, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [BIN_W-1:0] rb,
                           input logic typed, input logic [BIN_W-1:0] idx,
                           input logic [31:0] cnt, input logic [63:0] dens);
    directed_row_t row;
    row.word   = '{cmd: cmd, x_pos: x, y_pos: y, read_bin: rb};
    row.typed  = typed;
    row.report = '{bin_index: idx, bin_count: cnt, bin_density: dens};
    directed_rows.push_back(row);
  endtask

  // Half of the coordinates lie within the current grid or up to a quarter past its
  // edge to hit the axis clamp; the rest are full-range or the two extremes.
  function automatic logic [COORD_W-1:0] random_coord();
    logic [63:0] reach;
    logic [31:0] raw;
    raw = $urandom;
    if (grid_ibl == '0) reach = 64'hFF_FFFF;
    else reach = ({57'd0, grid_side()} << 32) / {40'd0, grid_ibl};
    reach = reach + (reach >> 2);
    if (reach > 64'hFF_FFFF) reach = 64'hFF_FFFF;
    case ($urandom_range(0, 7))
      0, 1:    return raw[COORD_W-1:0];
      2:       return '0;
      3:       return '1;
      default: return COORD_W'($urandom_range(0, reach[31:0]));
    endcase
  endfunction

  function automatic position_word_t random_word();
    position_word_t w;
    logic [31:0]    raw;
    raw        = $urandom;
    w.cmd      = ($urandom_range(0, 9) < 6) ? CMD_ADD : CMD_READ;
    w.x_pos    = random_coord();
    w.y_pos    = random_coord();
    w.read_bin = raw[BIN_W-1:0];
    if (w.cmd == CMD_READ && filled_bins.size() != 0 && $urandom_range(0, 9) < 7)
      w.read_bin = filled_bins[$urandom_range(0, filled_bins.size() - 1)];
    return w;
  endfunction

  // Holds the word on the bus until it is taken; tvalid stays high afterward.
  task automatic offer_word(input position_word_t w);
    s_tvalid <= 1'b1;
    s_tuser  <= w.cmd;
    s_tdata  <= {4'd0, w.read_bin, w.y_pos, w.x_pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    if (w.cmd == CMD_ADD) adds_sent++;
    else reads_sent++;
  endtask

  task automatic note_report(input position_word_t w, input bin_report_t r);
    awaited_reports.push_back(r);
    if (w.cmd == CMD_ADD) filled_bins.push_back(r.bin_index);
  endtask

  task automatic source_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic run_segment(input int count);
    position_word_t w;
    for (int k = 0; k < count; k++) begin
      w = random_word();
      offer_word(w);
      note_report(w, histogram_apply(w));
      source_gap();
    end
  endtask

  task automatic wait_drained();
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  // Writes all three registers back to back. Bits above each register's width
  // carry junk that the block must drop.
  task automatic load_settings(input logic [BPS_W-1:0] bps, input logic [IBL_W-1:0] ibl,
                               input logic [NORM_W-1:0] norm);
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_DATA_W-1:0] data [3];
    phd2_cfg_reg_t         regs [3];
    junk    = $urandom;
    regs[0] = CFG_BINS_PER_SIDE;
    regs[1] = CFG_INV_BIN_LEN;
    regs[2] = CFG_NORM_SCALE;
    data[0] = {junk[24:0], bps};
    data[1] = {junk[31:24], ibl};
    data[2] = norm;
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= data[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    grid_bps  = bps;
    grid_ibl  = ibl;
    grid_norm = norm;
    settings_loaded++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [BPS_W-1:0]  seg_bps  [N_SEGMENTS];
    logic [IBL_W-1:0]  seg_ibl  [N_SEGMENTS];
    logic [NORM_W-1:0] seg_norm [N_SEGMENTS];
    directed_row_t     row;
    bin_report_t       predicted;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tuser   <= CMD_ADD;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BINS_PER_SIDE;
    cfg_data  <= '0;

    grid_bps  = BPS_RST;
    grid_ibl  = IBL_RST;
    grid_norm = NORM_RST;
    for (int k = 0; k < GRID_CELLS; k++) bin_tally[k] = '0;

    // Settings: single-bin grid, code 0 (clamps to 1), code 127 (clamps to 64)
    // with the largest reciprocal, a zero reciprocal, then mid-range values.
    // The last segment runs without idling on either side.
    seg_bps  = '{7'd1, 7'd0, 7'd127, 7'd7, 7'd64, 7'($urandom_range(2, 63)), 7'd64};
    seg_ibl  = '{24'($urandom), 24'($urandom), 24'hFF_FFFF, 24'd0,
                 24'($urandom_range(1, 4000000)), 24'($urandom), IBL_RST};
    seg_norm = '{32'hFFFF_FFFF, 32'd1, $urandom, 32'hFFFF_FFFF, $urandom, $urandom,
                 $urandom};

    // Defaults after reset: 64 bins a side, bin edge between 3256 and 3257
    // in Q.8, density zero. Unused fields carry junk the block must ignore.
    stage_row(CMD_READ, 24'd0,      24'd0,      12'd0,    1, 12'd0,    32'd0, 64'd0);
    stage_row(CMD_READ, 24'hFFFFFF, 24'hFFFFFF, 12'd4095, 1, 12'd4095, 32'd0, 64'd0);
    stage_row(CMD_ADD,  24'd0,      24'd0,      12'hFFF,  1, 12'd0,    32'd1, 64'd0);
    stage_row(CMD_ADD,  24'd0,      24'd0,      12'd0,    1, 12'd0,    32'd2, 64'd0);
    stage_row(CMD_ADD,  24'hFFFFFF, 24'hFFFFFF, 12'd0,    1, 12'd4095, 32'd1, 64'd0);
    stage_row(CMD_READ, 24'hFFFFFF, 24'hFFFFFF, 12'd4095, 1, 12'd4095, 32'd1, 64'd0);
    stage_row(CMD_ADD,  24'd0,      24'hFFFFFF, 12'd0,    1, 12'd63,   32'd1, 64'd0);
    stage_row(CMD_ADD,  24'hFFFFFF, 24'd0,      12'd0,    1, 12'd4032, 32'd1, 64'd0);
    stage_row(CMD_ADD,  24'd3256,   24'd3257,   12'd0,    1, 12'd1,    32'd1, 64'd0);
    stage_row(CMD_ADD,  24'd3257,   24'd3256,   12'd0,    1, 12'd64,   32'd1, 64'd0);
    stage_row(CMD_ADD,  24'd3256,   24'd3256,   12'hAAA,  1, 12'd0,    32'd3, 64'd0);
    stage_row(CMD_READ, 24'd0,      24'd0,      12'd0,    1, 12'd0,    32'd3, 64'd0);
    stage_row(CMD_READ, 24'h123456, 24'h654321, 12'd1,    1, 12'd1,    32'd1, 64'd0);
    stage_row(CMD_READ, 24'd0,      24'd0,      12'd64,   1, 12'd64,   32'd1, 64'd0);
    stage_row(CMD_ADD,  24'h800000, 24'h00FFFF, 12'd0,    0, 12'd0,    32'd0, 64'd0);
    stage_row(CMD_ADD,  24'h555555, 24'hAAAAAA, 12'h555,  0, 12'd0,    32'd0, 64'd0);
    stage_row(CMD_READ, 24'hAAAAAA, 24'h555555, 12'hAAA,  0, 12'd0,    32'd0, 64'd0);
    stage_row(CMD_READ, 24'd0,      24'd0,      12'h555,  0, 12'd0,    32'd0, 64'd0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part; the block first clears its RAM, which holds off s_tready.
    foreach (directed_rows[k]) begin
      row       = directed_rows[k];
      offer_word(row.word);
      predicted = histogram_apply(row.word);
      note_report(row.word, row.typed ? row.report : predicted);
      source_gap();
    end
    run_segment(WORDS_PER_SEGMENT);

    for (int seg = 0; seg < N_SEGMENTS; seg++) begin
      // Registers change only with the pipeline empty; the source waits here.
      s_tvalid <= 1'b0;
      wait_drained();
      if (seg == N_SEGMENTS - 1) calm = 1'b1;
      load_settings(seg_bps[seg], seg_ibl[seg], seg_norm[seg]);
      if (seg == HOLD_SEGMENT) hold_asks++;
      run_segment(WORDS_PER_SEGMENT);
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (12) @(posedge clk);

    $display("%0d words sent (%0d position adds, %0d bin reads), %0d results checked",
             words_sent, adds_sent, reads_sent, reports_checked);
    $display("%0d register settings loaded, grid sizes 1 to 64 incl. clamped codes",
             settings_loaded + 1);
    if (failures == 0 && awaited_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts, plus one long hold on request so the
  // output register and then the input side back up.
  // ---------------------------------------------------------------------------
  initial begin
    int holds_served;
    int held;
    holds_served = 0;
    m_tready <= 1'b0;
    forever begin
      if (hold_asks != holds_served) begin
        holds_served++;
        m_tready <= 1'b0;
        held = 0;
        while (held < LONG_HOLD) begin
          @(posedge clk);
          held++;
        end
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_reports
    bin_report_t got;
    bin_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.bin_index   = m_tdata[11:0];
      got.bin_count   = m_tdata[43:12];
      got.bin_density = m_tdata[107:44];
      reports_checked++;
      if (awaited_reports.size() == 0) begin
        $error("result word with nothing pending: bin_index %0d", got.bin_index);
        failures++;
      end else begin
        want = awaited_reports.pop_front();
        if (got.bin_index !== want.bin_index) begin
          $error("bin_index: expected %0d, got %0d", want.bin_index, got.bin_index);
          failures++;
        end
        if (got.bin_count !== want.bin_count) begin
          $error("bin_count: expected %0d, got %0d", want.bin_count, got.bin_count);
          failures++;
        end
        if (got.bin_density !== want.bin_density) begin
          $error("bin_density: expected %h, got %h", want.bin_density, got.bin_density);
          failures++;
        end
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("stalled for %0d cycles, %0d results pending", quiet_cycles,
               awaited_reports.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
